[sv/kvp_pkg.sv]
// Package for the key=value dword list parser.
// Holds the character codes, queue sizing and the classified item type.
// No dependencies; imported by every module of the block.
package kvp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] CNT_SAT = 2'd3;

    // one text byte after classification
    typedef struct packed {
        logic       present;
        logic       last;
        logic       comma;
        logic       eq;
        logic       x_char;
        logic       zero_char;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] nib;
    } kvp_item_t;

endpackage

[sv/kvp_front.sv]
// Front end: accepts text bytes and classifies them.
// Depends on kvp_pkg; pushes kvp_item_t into kvp_queue.
module kvp_front
    import kvp_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       char_present,
    input  logic       end_of_text,
    input  logic       q_full,
    output logic       q_push,
    output kvp_item_t  q_item
);

    logic is_dec;
    logic is_lo_hex;
    logic is_up_hex;

    always_comb
    begin
        is_dec    = (char_code >= 8'h30) && (char_code <= 8'h39);
        is_lo_hex = (char_code >= 8'h61) && (char_code <= 8'h66);
        is_up_hex = (char_code >= 8'h41) && (char_code <= 8'h46);

        q_item.present   = char_present;
        q_item.last      = end_of_text;
        q_item.comma     = (char_code == CH_COMMA);
        q_item.eq        = (char_code == CH_EQ);
        q_item.x_char    = (char_code == CH_UX) || (char_code == CH_LX);
        q_item.zero_char = (char_code == CH_ZERO);
        q_item.dec_ok    = is_dec;
        q_item.hex_ok    = is_dec || is_lo_hex || is_up_hex;
        // letters a-f / A-F have low nibble 1..6, digit value is that plus 9
        q_item.nib       = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

[sv/kvp_queue.sv]
// Short FIFO between the classifier and the accumulator back end.
// Depends on kvp_pkg; fall-through read of the head entry.
module kvp_queue
    import kvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  kvp_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output kvp_item_t head_item
);

    kvp_item_t          store [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

[sv/kvp_back.sv]
// Back end: accumulates key and value parts, closes entries into the
// output register. Depends on kvp_pkg; fed from kvp_queue.
module kvp_back
    import kvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  kvp_item_t   q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key,
    output logic [31:0] value,
    output logic        pair_valid,
    output logic        text_done
);

    logic        in_val_reg,  in_val_next;
    logic        key_ok_reg,  key_ok_next;
    logic [31:0] kacc_reg,    kacc_next;
    logic [31:0] vacc_reg,    vacc_next;
    logic [1:0]  cnt_reg,     cnt_next;
    logic        hex_reg,     hex_next;
    logic        pz_reg,      pz_next;
    logic        err_reg,     err_next;

    logic        ov_reg;
    logic [31:0] okey_reg;
    logic [31:0] oval_reg;
    logic        opv_reg;
    logic        odone_reg;

    logic        close;
    logic        slot_free;
    logic        ok;
    logic [31:0] acc;
    logic [35:0] acc_dec;
    logic [35:0] acc_hex;
    logic [35:0] acc_new;
    logic        digit_ok;

    function automatic logic part_good(logic [1:0] cnt, logic err, logic hex);
        part_good = (cnt != 2'd0) && !err && !(hex && (cnt == 2'd2));
    endfunction

    assign close     = q_item.comma && q_item.present || q_item.last;
    assign slot_free = !ov_reg || !out_stall;
    assign q_pop     = !q_empty && (!close || slot_free);

    always_comb
    begin
        acc      = in_val_reg ? vacc_reg : kacc_reg;
        acc_dec  = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {32'b0, q_item.nib};
        acc_hex  = {acc, q_item.nib};
        acc_new  = hex_reg ? acc_hex : acc_dec;
        digit_ok = hex_reg ? q_item.hex_ok : q_item.dec_ok;

        // state after the character, before any close
        in_val_next = in_val_reg;
        key_ok_next = key_ok_reg;
        kacc_next   = kacc_reg;
        vacc_next   = vacc_reg;
        cnt_next    = cnt_reg;
        hex_next    = hex_reg;
        pz_next     = pz_reg;
        err_next    = err_reg;

        if (q_item.present && !q_item.comma)
        begin
            if (q_item.eq && !in_val_reg)
            begin
                key_ok_next = part_good(cnt_reg, err_reg, hex_reg);
                in_val_next = 1'b1;
                cnt_next    = 2'd0;
                hex_next    = 1'b0;
                pz_next     = 1'b0;
                err_next    = 1'b0;
            end
            else
            begin
                if (!err_reg)
                begin
                    if ((cnt_reg == 2'd1) && pz_reg && !hex_reg && q_item.x_char)
                        hex_next = 1'b1;
                    else if (!digit_ok || (acc_new[35:32] != 4'd0))
                        err_next = 1'b1;
                    else if (in_val_reg)
                        vacc_next = acc_new[31:0];
                    else
                        kacc_next = acc_new[31:0];
                end
                if ((cnt_reg == 2'd0) && q_item.zero_char)
                    pz_next = 1'b1;
                if (cnt_reg != CNT_SAT)
                    cnt_next = cnt_reg + 2'd1;
            end
        end

        ok = in_val_next && key_ok_next && part_good(cnt_next, err_next, hex_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_val_reg <= 1'b0;
            key_ok_reg <= 1'b0;
            kacc_reg   <= '0;
            vacc_reg   <= '0;
            cnt_reg    <= '0;
            hex_reg    <= 1'b0;
            pz_reg     <= 1'b0;
            err_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (close)
                begin
                    in_val_reg <= 1'b0;
                    key_ok_reg <= 1'b0;
                    kacc_reg   <= '0;
                    vacc_reg   <= '0;
                    cnt_reg    <= '0;
                    hex_reg    <= 1'b0;
                    pz_reg     <= 1'b0;
                    err_reg    <= 1'b0;
                end
                else
                begin
                    in_val_reg <= in_val_next;
                    key_ok_reg <= key_ok_next;
                    kacc_reg   <= kacc_next;
                    vacc_reg   <= vacc_next;
                    cnt_reg    <= cnt_next;
                    hex_reg    <= hex_next;
                    pz_reg     <= pz_next;
                    err_reg    <= err_next;
                end
            end
            if (q_pop && close)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && close)
        begin
            okey_reg  <= ok ? kacc_next : 32'd0;
            oval_reg  <= ok ? vacc_next : 32'd0;
            opv_reg   <= ok;
            odone_reg <= q_item.last;
        end
    end

    assign out_valid  = ov_reg;
    assign key        = okey_reg;
    assign value      = oval_reg;
    assign pair_valid = opv_reg;
    assign text_done  = odone_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !opv_reg) |-> (okey_reg == 32'd0 && oval_reg == 32'd0))
        else $error("invalid pair carries nonzero data");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |-> !(q_pop && close))
        else $error("result overwrites a stalled one");

    a_hex_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        hex_reg |-> (pz_reg && cnt_reg >= 2'd2))
        else $error("hex mode without 0x prefix");

    a_key_ok_only_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        key_ok_reg |-> in_val_reg)
        else $error("key marked good while still in key part");

endmodule

[sv/key_value_dword_list_parser_top.sv]
// Top level of the comma separated key=value dword list parser.
// Depends on kvp_pkg, kvp_front, kvp_queue and kvp_back.
//
//  channel | signals                                   | dir | flow
//  --------+-------------------------------------------+-----+------------------
//  in      | in_valid, in_stall, char_code,            | in  | one byte/transfer
//          | char_present, end_of_text                 |     |
//  out     | out_valid, out_stall, key, value,         | out | one closed entry
//          | pair_valid, text_done                     |     | per transfer
//
// One byte per cycle is sustained unless out_stall holds back a closing
// byte. A byte enters the four-entry queue on the cycle it transfers and is
// registered there before the back end can consume it; the multiply-by-ten
// (or shift-by-four) and add of the active accumulator is the single step
// done per byte. A closing byte (comma or end of text) lands in the output
// register at the edge that pops it from the queue, so its result passes
// through the queue and the output register before it can transfer.
// Reset: rst_n clears the queue pointers, parse state and output valid.
// Stalls: out_stall holds the result register; bytes that close no entry
// keep draining, closing bytes wait, and in_stall rises once the queue
// is full.
module key_value_dword_list_parser_top
    import kvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        char_present,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key,
    output logic [31:0] value,
    output logic        pair_valid,
    output logic        text_done
);

    kvp_item_t push_item;
    kvp_item_t head_item;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    // classify each byte as it transfers in
    kvp_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .char_present (char_present),
        .end_of_text  (end_of_text),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    // decouples input acceptance from result back-pressure
    kvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    // accumulate parts, close entries into the output register
    kvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key        (key),
        .value      (value),
        .pair_valid (pair_valid),
        .text_done  (text_done)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for key_value_dword_list_parser_top.
// Depends on kvp_pkg for the character codes and on the RTL of the block.

module tb_top
    import kvp_pkg::*;
();

    // Longest stretch without any transfer before the run is called hung.
    // The deliberate receiver hold-off and the random gaps stay well below
    // it, so the limit sits far above any correct run.
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 80;
    localparam int TAIL_CYCLES = 16;
    localparam int PHASE_BYTES = 450;

    typedef struct packed {
        logic [7:0] code;
        logic       present;
        logic       last;
    } text_byte_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic        ok;
        logic        done;
    } kv_pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        char_present;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] key;
    logic [31:0] value;
    logic        pair_valid;
    logic        text_done;

    // Bytes waiting to be driven, pairs waiting to come out, and the text
    // under construction before it is handed to the driver.
    text_byte_t  byte_queue[$];
    kv_pair_t    pending_pairs[$];
    logic [7:0]  text_buf[$];

    // Handshake bookkeeping shared between the rising-edge monitor and the falling-edge drivers.
    int in_sent       = 0;
    int in_accepted   = 0;
    int out_taken     = 0;
    int out_seen      = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    bit in_steady     = 0;
    bit out_steady    = 0;
    bit sprinkle      = 0;

    int errors        = 0;
    int idle_cycles   = 0;
    int stim_bytes    = 0;
    int ignored_bytes = 0;
    int results_seen  = 0;
    int valid_seen    = 0;
    int done_seen     = 0;

    // Parser state as the predictor sees it.
    logic        st_in_value  = 1'b0;
    logic [31:0] st_key       = '0;
    logic [31:0] st_value     = '0;
    logic [1:0]  st_count     = '0;
    logic        st_hex       = 1'b0;
    logic        st_lead_zero = 1'b0;
    logic        st_key_ok    = 1'b0;
    logic        st_error     = 1'b0;

    key_value_dword_list_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .char_present (char_present),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key          (key),
        .value        (value),
        .pair_valid   (pair_valid),
        .text_done    (text_done)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A part is usable when it has characters, no error, and is not a
    // bare hex prefix.
    function automatic bit part_well_formed();
        return st_count != 2'd0 && !st_error && !(st_hex && st_count == 2'd2);
    endfunction

    task automatic clear_part();
        st_count     = '0;
        st_hex       = 1'b0;
        st_lead_zero = 1'b0;
        st_error     = 1'b0;
    endtask

    // Closing an entry always yields one pair; key and value read zero
    // unless both sides were well formed.
    task automatic close_pair(input logic done);
        kv_pair_t p;
        logic     ok;
        ok      = st_in_value && st_key_ok && part_well_formed();
        p.key   = ok ? st_key : '0;
        p.value = ok ? st_value : '0;
        p.ok    = ok;
        p.done  = done;
        pending_pairs.push_back(p);
        st_in_value = 1'b0;
        st_key      = '0;
        st_value    = '0;
        st_key_ok   = 1'b0;
        clear_part();
    endtask

    task automatic parse_text_byte(input logic [7:0] c, input logic present,
                                   input logic last);
        int          d;
        logic [31:0] acc;
        logic [63:0] nxt;
        logic        closed;
        closed = 1'b0;
        if (present)
        begin
            if (c == CH_COMMA)
            begin
                close_pair(last);
                closed = 1'b1;
            end
            else if (c == CH_EQ && !st_in_value)
            begin
                st_key_ok   = part_well_formed();
                st_in_value = 1'b1;
                clear_part();
            end
            else
            begin
                acc = st_in_value ? st_value : st_key;
                if (!st_error)
                begin
                    if (st_count == 2'd1 && st_lead_zero && !st_hex &&
                        (c == CH_LX || c == CH_UX))
                    begin
                        st_hex = 1'b1;
                    end
                    else
                    begin
                        d = -1;
                        if (c >= "0" && c <= "9")
                            d = int'(c) - int'("0");
                        else if (st_hex && c >= "a" && c <= "f")
                            d = int'(c) - int'("a") + 10;
                        else if (st_hex && c >= "A" && c <= "F")
                            d = int'(c) - int'("A") + 10;
                        if (d < 0)
                        begin
                            st_error = 1'b1;
                        end
                        else
                        begin
                            nxt = {32'd0, acc} * (st_hex ? 64'd16 : 64'd10) + 64'(d);
                            if (nxt > 64'hFFFF_FFFF)
                                st_error = 1'b1;
                            else if (st_in_value)
                                st_value = nxt[31:0];
                            else
                                st_key = nxt[31:0];
                        end
                    end
                end
                if (st_count == 2'd0 && c == CH_ZERO)
                    st_lead_zero = 1'b1;
                if (st_count < CNT_SAT)
                    st_count = st_count + 2'd1;
            end
        end
        if (last && !closed)
            close_pair(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next byte at the falling edge once the current
    // one has been taken, after the drawn number of idle cycles.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_bytes
        text_byte_t item;
        bit         busy;
        if (rst_n)
        begin
            busy = in_valid && (in_accepted != in_sent);
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_queue.size() > 0)
                begin
                    item = byte_queue.pop_front();
                    char_code    <= item.code;
                    char_present <= item.present;
                    end_of_text  <= item.last;
                    in_valid     <= 1'b1;
                    in_sent++;
                    gap_left = in_steady ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: after each result transfer it draws how long to stall;
    // a pending hold request overrides that with one long stall.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (hold_served < hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (out_taken != out_seen)
            begin
                out_seen   = out_taken;
                stall_left = out_steady ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result transfers against the oldest prediction,
    // then feeds accepted input transfers to the predictor.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        kv_pair_t exp_pair;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                out_taken++;
                results_seen++;
                if (pair_valid === 1'b1)
                    valid_seen++;
                if (text_done === 1'b1)
                    done_seen++;
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual key %h value %h",
                             $time, key, value);
                end
                else
                begin
                    exp_pair = pending_pairs.pop_front();
                    check_field("key", exp_pair.key, key);
                    check_field("value", exp_pair.value, value);
                    check_field("pair_valid", 32'(exp_pair.ok), 32'(pair_valid));
                    check_field("text_done", 32'(exp_pair.done), 32'(text_done));
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                in_accepted++;
                parse_text_byte(char_code, char_present, end_of_text);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("key_value_dword_list_parser_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] c, input logic present, input logic last);
        text_byte_t item;
        item.code    = c;
        item.present = present;
        item.last    = last;
        byte_queue.push_back(item);
        if (present || last)
            stim_bytes++;
        else
            ignored_bytes++;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Hands the built text to the driver; in the random part an absent
    // byte without end is slipped in now and then, which must be ignored.
    task automatic flush_text(input bit end_on_last);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if (sprinkle && $urandom_range(0, 29) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(text_buf[i], 1'b1, end_on_last && i == n - 1);
        end
        text_buf.delete();
    endtask

    // One number: decimal or hex with random letter case, extremes and
    // boundary values, and now and then one that no longer fits 32 bits.
    task automatic add_number();
        logic [31:0]     v;
        longint unsigned big;
        string           s;
        int              kind;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 15);
            3:       v = 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: v = $urandom;
        endcase
        if (kind < 4)
        begin
            s = $sformatf("%0d", v);
            if (kind == 0)
                s = {"0", s};
        end
        else if (kind < 7)
        begin
            s = {($urandom_range(0, 1) ? "0x" : "0X"), $sformatf("%0h", v)};
        end
        else if (kind == 7)
        begin
            s = {($urandom_range(0, 1) ? "0x" : "0X"), $sformatf("%08h", v)};
        end
        else if (kind == 8)
        begin
            big = 64'h1_0000_0000 + $urandom_range(0, 999);
            s = $sformatf("%0d", big);
        end
        else
        begin
            big = {32'($urandom_range(1, 15)), 32'($urandom)};
            s = {"0x", $sformatf("%0h", big)};
        end
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1))
                text_buf.push_back(s[i] - 8'd32);
            else
                text_buf.push_back(s[i]);
        end
    endtask

    // Mostly well-formed pairs; the rest are the broken shapes and noise.
    task automatic add_entry();
        string charset;
        int    r;
        int    n;
        charset = "0123456789aFxX=g +-";
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            add_number();
            text_buf.push_back(CH_EQ);
            add_number();
        end
        else if (r < 75)
        begin
            add_number();
        end
        else if (r < 80)
        begin
            text_buf.push_back(CH_EQ);
            add_number();
        end
        else if (r < 84)
        begin
            add_number();
            text_buf.push_back(CH_EQ);
        end
        else if (r < 88)
        begin
            if ($urandom_range(0, 1))
            begin
                add_str($urandom_range(0, 1) ? "0x=" : "0X=");
                add_number();
            end
            else
            begin
                add_number();
                add_str($urandom_range(0, 1) ? "=0x" : "=0X");
            end
        end
        else if (r < 92)
        begin
            add_number();
            text_buf.push_back(CH_EQ);
            add_number();
            text_buf.push_back(CH_EQ);
            add_number();
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1))
                    text_buf.push_back(8'($urandom_range(0, 255)));
                else
                    text_buf.push_back(charset[$urandom_range(0, charset.len() - 1)]);
            end
        end
    endtask

    // Texts of one to four entries, closed by the last character, by a
    // trailing comma, or by an absent end byte.
    task automatic random_texts(input int n_bytes);
        int first;
        int n_ent;
        int ending;
        first = stim_bytes;
        while (stim_bytes - first < n_bytes)
        begin
            n_ent = $urandom_range(1, 4);
            for (int k = 0; k < n_ent; k++)
            begin
                if (k > 0)
                    text_buf.push_back(CH_COMMA);
                add_entry();
            end
            ending = $urandom_range(0, 3);
            if (ending == 1)
            begin
                text_buf.push_back(CH_COMMA);
                flush_text(1'b1);
            end
            else if (ending == 0 && text_buf.size() > 0)
            begin
                flush_text(1'b1);
            end
            else
            begin
                flush_text(1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
    endtask

    // Sender pause: nothing more is offered until every byte is taken and
    // every predicted pair has come out. Returns at a rising edge.
    task automatic wait_drain();
        while (byte_queue.size() != 0 || in_sent != in_accepted || pending_pairs.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_code    = '0;
        char_present = 1'b0;
        end_of_text  = 1'b0;
        out_stall    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a good pair, no '=', empty key, bare hex prefix, sign
        // character, and a comma that ends the text.
        add_str("1=2,3,=5,0X=1,8=+,");
        flush_text(1'b1);
        // empty text: absent byte with end
        push_item(8'h00, 1'b0, 1'b1);
        // second '=' inside the value, then an ignored absent byte
        add_str("1==,");
        flush_text(1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        // top code as a character, closed by an absent end byte
        text_buf.push_back(8'hFF);
        flush_text(1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        wait_drain();

        // Random phases: mixed idling, then no idling at all, then a long
        // receiver hold-off while the sender keeps offering, then mixed.
        sprinkle = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            in_steady  = (phase == 1 || phase == 2);
            out_steady = (phase == 1);
            if (phase == 2)
                hold_requests++;
            random_texts(PHASE_BYTES);
            wait_drain();
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;

        // Catch any stray result after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Run covered %0d text bytes plus %0d ignored absent bytes,", stim_bytes,
                 ignored_bytes);
        $display("closing %0d entries: %0d well-formed pairs, %0d text ends.", results_seen,
                 valid_seen, done_seen);
        if (errors == 0)
            $display("key_value_dword_list_parser_top verification clean");
        else
            $display("key_value_dword_list_parser_top verification failed");
        $finish;
    end

endmodule

[sim.f]
sv/kvp_pkg.sv
sv/kvp_front.sv
sv/kvp_queue.sv
sv/kvp_back.sv
sv/key_value_dword_list_parser_top.sv
tb/tb_top.sv
